@@ design/rlm_pkg.sv @@
// Shared types and command codes for the raycast light map unit.
`default_nettype none

package rlm_pkg;

	localparam int COORD_W  = 6;
	localparam int CMD_W    = 2;
	localparam int RADIUS_W = 4;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CAST  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd3;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic               wall_bit;
	} in_item_t;

	typedef struct packed {
		logic             lit_bit;
		logic [CMD_W-1:0] done_cmd;
	} out_item_t;

endpackage

`default_nettype wire

@@ design/rlm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rlm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ design/raycast_light_map_unit.sv @@
// Top level of the raycast light map unit: wall and lit grids with a line-walking caster.
`default_nettype none

// A write or an unknown command goes from acceptance through ST_FIN to a result, a read
// through ST_RD and ST_FIN. A cast scans all (2r+1)^2 candidate targets in ST_TGT and
// walks a line to each target in range through ST_WA and ST_WB, because every visited
// cell waits for the registered read of the wall memory before the walk may go on.
// After reset a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells zeroes both grids;
// no command is accepted during it, while radius writes are taken at any time. The
// radius in effect is the configured radius (radius_q) capped at MAX_RADIUS and is
// sampled when a cast is accepted.
module raycast_light_map_unit #(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64,
	parameter int MAX_RADIUS  = 15
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire rlm_pkg::in_item_t              in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output rlm_pkg::out_item_t                  out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rlm_pkg::RADIUS_W-1:0]   cfg_data
);

	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int CW    = $clog2((1 << rlm_pkg::COORD_W) + MAX_RADIUS) + 1;
	localparam int EW    = RW + 3;
	localparam int SW    = 2 * RW + 1;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_TGT  = 3'd3;
	localparam logic [2:0] ST_WA   = 3'd4;
	localparam logic [2:0] ST_WB   = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	function automatic logic on_map(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
		return !x[CW-1] && !y[CW-1]
			&& ({{(32-CW){1'b0}}, x} < 32'(GRID_WIDTH))
			&& ({{(32-CW){1'b0}}, y} < 32'(GRID_HEIGHT));
	endfunction

	function automatic logic [AW-1:0] cell_addr(logic signed [CW-1:0] x,
		logic signed [CW-1:0] y);
		return AW'({{(32-CW){1'b0}}, y} * 32'(GRID_WIDTH) + {{(32-CW){1'b0}}, x});
	endfunction

	logic [2:0]                     state_q;
	logic [AW-1:0]                  clr_addr_q;
	logic [rlm_pkg::RADIUS_W-1:0]   radius_q;
	logic                           out_valid_q;
	rlm_pkg::out_item_t             out_data_q;

	logic [rlm_pkg::CMD_W-1:0]      cmd_q;
	logic                           pend_lit_q;
	logic                           rd_on_q;
	logic [RW-1:0]                  r_q;
	logic [SW-1:0]                  rsq_q;
	logic signed [RW:0]             dx_q;
	logic signed [RW:0]             dy_q;
	logic signed [CW-1:0]           lx_q;
	logic signed [CW-1:0]           ly_q;
	logic signed [CW-1:0]           x_q;
	logic signed [CW-1:0]           y_q;
	logic signed [CW-1:0]           tx_q;
	logic signed [CW-1:0]           ty_q;
	logic [RW:0]                    ax_q;
	logic [RW:0]                    ay_q;
	logic                           sx_q;
	logic                           sy_q;
	logic signed [EW-1:0]           err_q;

	logic                           in_acc;
	logic signed [CW-1:0]           in_x;
	logic signed [CW-1:0]           in_y;
	logic                           in_on;
	logic [AW-1:0]                  in_addr;
	logic [RW-1:0]                  r_cl;

	logic signed [RW:0]             rs;
	logic [RW:0]                    adx;
	logic [RW:0]                    ady;
	logic signed [CW-1:0]           tx_c;
	logic signed [CW-1:0]           ty_c;
	logic [SW-1:0]                  dsq_c;
	logic                           tgt_ok;
	logic                           last_tgt;
	logic signed [RW:0]             dx_nx;
	logic signed [RW:0]             dy_nx;

	logic                           walk_on;
	logic [AW-1:0]                  walk_addr;
	logic                           at_tgt;
	logic signed [EW-1:0]           twice;
	logic signed [EW-1:0]           ax_s;
	logic signed [EW-1:0]           ay_s;
	logic                           c1;
	logic                           c2;
	logic                           walk_stop;
	logic                           out_free;

	logic                           wall_we;
	logic [AW-1:0]                  wall_waddr;
	logic                           wall_wdata;
	logic                           wall_rdata;
	logic                           lit_we;
	logic [AW-1:0]                  lit_waddr;
	logic                           lit_wdata;
	logic                           lit_rdata;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign in_acc  = in_valid && in_ready;
	assign in_x    = signed'(CW'(in_data.cell_x));
	assign in_y    = signed'(CW'(in_data.cell_y));
	assign in_on   = on_map(in_x, in_y);
	assign in_addr = cell_addr(in_x, in_y);
	assign r_cl    = ({{(32-rlm_pkg::RADIUS_W){1'b0}}, radius_q} > 32'(MAX_RADIUS))
		? RW'(MAX_RADIUS) : RW'(radius_q);

	// target scan
	assign rs     = signed'({1'b0, r_q});
	assign adx    = dx_q[RW] ? unsigned'(-dx_q) : unsigned'(dx_q);
	assign ady    = dy_q[RW] ? unsigned'(-dy_q) : unsigned'(dy_q);
	assign tx_c   = lx_q + CW'(dx_q);
	assign ty_c   = ly_q + CW'(dy_q);
	assign dsq_c  = SW'(adx) * SW'(adx) + SW'(ady) * SW'(ady);
	assign tgt_ok = on_map(tx_c, ty_c) && (dsq_c <= rsq_q);
	assign last_tgt = (dx_q == rs) && (dy_q == rs);
	assign dy_nx  = (dy_q == rs) ? -rs : dy_q + (RW+1)'(1);
	assign dx_nx  = (dy_q == rs) ? dx_q + (RW+1)'(1) : dx_q;

	// line walk
	assign walk_on   = on_map(x_q, y_q);
	assign walk_addr = cell_addr(x_q, y_q);
	assign at_tgt    = (x_q == tx_q) && (y_q == ty_q);
	assign twice     = err_q <<< 1;
	assign ax_s      = signed'(EW'(ax_q));
	assign ay_s      = signed'(EW'(ay_q));
	assign c1        = twice > -ay_s;
	assign c2        = twice < ax_s;
	assign walk_stop = (walk_on && wall_rdata) || at_tgt;
	assign out_free  = !out_valid_q || out_ready;

	assign wall_we    = (state_q == ST_CLR)
		|| (in_acc && in_data.cmd == rlm_pkg::CMD_WRITE && in_on);
	assign wall_waddr = (state_q == ST_CLR) ? clr_addr_q : in_addr;
	assign wall_wdata = (state_q == ST_CLR) ? 1'b0 : in_data.wall_bit;
	assign lit_we     = (state_q == ST_CLR) || (state_q == ST_WA && walk_on);
	assign lit_waddr  = (state_q == ST_CLR) ? clr_addr_q : walk_addr;
	assign lit_wdata  = (state_q != ST_CLR);

	rlm_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_wall_ram (
		.clk  (clk),
		.we   (wall_we),
		.waddr(wall_waddr),
		.wdata(wall_wdata),
		.raddr(walk_addr),
		.rdata(wall_rdata)
	);

	rlm_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_lit_ram (
		.clk  (clk),
		.we   (lit_we),
		.waddr(lit_waddr),
		.wdata(lit_wdata),
		.raddr(in_addr),
		.rdata(lit_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_addr_q  <= '0;
			radius_q    <= rlm_pkg::RADIUS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radius_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (in_data.cmd)
							rlm_pkg::CMD_READ: state_q <= ST_RD;
							rlm_pkg::CMD_CAST: state_q <= ST_TGT;
							default:           state_q <= ST_FIN;
						endcase
					end
				end
				ST_RD: state_q <= ST_FIN;
				ST_TGT: begin
					if (tgt_ok) begin
						state_q <= ST_WA;
					end else if (last_tgt) begin
						state_q <= ST_FIN;
					end
				end
				ST_WA: state_q <= ST_WB;
				ST_WB: begin
					if (!walk_stop) begin
						state_q <= ST_WA;
					end else if (last_tgt) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_TGT;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd_q      <= in_data.cmd;
					pend_lit_q <= 1'b0;
					rd_on_q    <= in_on;
					lx_q       <= in_x;
					ly_q       <= in_y;
					r_q        <= r_cl;
					rsq_q      <= SW'(r_cl) * SW'(r_cl);
					dx_q       <= -signed'({1'b0, r_cl});
					dy_q       <= -signed'({1'b0, r_cl});
				end
			end
			ST_RD: pend_lit_q <= rd_on_q && lit_rdata;
			ST_TGT: begin
				if (tgt_ok) begin
					x_q   <= lx_q;
					y_q   <= ly_q;
					tx_q  <= tx_c;
					ty_q  <= ty_c;
					ax_q  <= adx;
					ay_q  <= ady;
					sx_q  <= !dx_q[RW] && (dx_q != '0);
					sy_q  <= !dy_q[RW] && (dy_q != '0);
					err_q <= signed'(EW'(adx)) - signed'(EW'(ady));
				end else begin
					dx_q <= dx_nx;
					dy_q <= dy_nx;
				end
			end
			ST_WB: begin
				if (walk_stop) begin
					dx_q <= dx_nx;
					dy_q <= dy_nx;
				end else begin
					err_q <= err_q - (c1 ? ay_s : '0) + (c2 ? ax_s : '0);
					if (c1) begin
						x_q <= sx_q ? x_q + CW'(1) : x_q - CW'(1);
					end
					if (c2) begin
						y_q <= sy_q ? y_q + CW'(1) : y_q - CW'(1);
					end
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_data_q.lit_bit  <= pend_lit_q;
					out_data_q.done_cmd <= cmd_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_lit_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		lit_we |-> (state_q == ST_WA || state_q == ST_CLR))
		else $error("lit grid written outside walk or clear");

	a_wall_read_before_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |-> ($past(state_q) == ST_WA))
		else $error("wall check without a preceding wall read");

	a_wall_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		(wall_we && state_q != ST_CLR) |-> (state_q == ST_IDLE && in_acc))
		else $error("wall grid written outside an accepted write");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
		else $error("result raised outside the finish step");

	a_read_goes_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_data.cmd == rlm_pkg::CMD_READ) |=> (state_q == ST_RD))
		else $error("accepted read did not wait for lit data");
`endif

endmodule

`default_nettype wire
